FILE: rtl/ftab_pkg.sv
// Shared types and constants for the TCP flow last-seen table.
`default_nettype none
package ftab_pkg;

    localparam int TableDepthDefault = 64;
    localparam int OffsetWidth = 18;
    localparam logic [OffsetWidth-1:0] OffsetReset = 18'd28800;
    localparam int IndexOutWidth = 6;
    localparam int ApbAddrWidth = 3;
    localparam logic [ApbAddrWidth-1:0] AddrTimeOffset = 3'd0;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_ENC,
        ST_UPD
    } back_state_t;

    // One input item; stamp is the packet time or, after the front, the offset time.
    typedef struct packed {
        op_t         op;
        logic [31:0] src_ip;
        logic [15:0] sport;
        logic [31:0] dst_ip;
        logic [15:0] dport;
        logic [31:0] stamp;
        logic        has_payload;
        logic [5:0]  read_index;
    } item_t;

    typedef struct packed {
        logic        entry_valid;
        logic [5:0]  entry_index;
        logic        was_new;
        logic        table_full;
        logic [31:0] flow_src_ip;
        logic [15:0] flow_sport;
        logic [31:0] flow_dst_ip;
        logic [15:0] flow_dport;
        logic [31:0] last_any_time;
        logic [31:0] last_payload_time;
        logic [31:0] last_flag_time;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/ftab_front.sv
// Front part: accepts items, applies the time offset and queues them.
`default_nettype none
module ftab_front
    import ftab_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire item_t                  in_item,
    input  wire logic [OffsetWidth-1:0] time_offset,
    output logic                        q_valid,
    input  wire logic                   q_pop,
    output item_t                       q_item
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic [31:0] off_ext;
    item_t       stamped;

    // Sign-extend the offset and add it modulo 2^32.
    always_comb
    begin
        off_ext = {{(32-OffsetWidth){time_offset[OffsetWidth-1]}}, time_offset};
        stamped = in_item;
        stamped.stamp = in_item.stamp + off_ext;
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    // Queue pointers and occupancy.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= stamped;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ftab_back.sv
// Back part: key match, entry update and the output register.
`default_nettype none
module ftab_back
    import ftab_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDefault
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    output logic       q_pop,
    input  wire item_t q_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_res
);

    localparam int IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FillW = $clog2(TABLE_DEPTH + 1);
    localparam int WideW = IdxW + IndexOutWidth;
    localparam logic [WideW-1:0] DepthWide = WideW'(TABLE_DEPTH);
    localparam logic [FillW-1:0] DepthFill = FillW'(TABLE_DEPTH);

    back_state_t            state_reg, state_next;
    item_t                  item_reg;
    logic [TABLE_DEPTH-1:0] used_reg;
    logic [TABLE_DEPTH-1:0] match_reg;
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [FillW-1:0]       fill_reg;
    logic [95:0]            key_reg [TABLE_DEPTH];
    logic [95:0]            key_rd_reg;
    logic [IdxW-1:0]        sel_idx_reg, sel_idx_next;
    logic                   found_reg, found_next;
    logic                   out_valid_reg;
    result_t                out_res_reg;

    logic [31:0] any_mem [TABLE_DEPTH];
    logic [31:0] pay_mem [TABLE_DEPTH];
    logic [31:0] flag_mem [TABLE_DEPTH];
    logic [31:0] any_rd_reg, pay_rd_reg, flag_rd_reg;

    logic [IdxW-1:0]  enc_idx;
    logic [WideW-1:0] ri_wide;
    logic             slot_free;
    logic             do_upd;
    logic             tbl_write, key_write;
    logic [IdxW-1:0]  wr_idx;
    logic [31:0]      any_w, pay_w, flag_w;
    result_t          res;
    logic [WideW-1:0] idx_wide;

    assign slot_free = !out_valid_reg || out_ready;
    assign do_upd    = (state_reg == ST_UPD) && slot_free;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // One comparator per entry against the held key.
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match_vec[i] = used_reg[i] && (key_reg[i] ==
                {item_reg.src_ip, item_reg.dst_ip, item_reg.sport, item_reg.dport});
        end
    end

    // Keys are unique, so the matches form at most one hot bit: OR the indices.
    always_comb
    begin
        enc_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            enc_idx = enc_idx | (match_reg[i] ? IdxW'(i) : '0);
        end
    end

    // Pick the entry to act on.
    always_comb
    begin
        ri_wide = {{IdxW{1'b0}}, item_reg.read_index};
        unique case (item_reg.op)
            OP_READ:
            begin
                sel_idx_next = ri_wide[IdxW-1:0];
                found_next   = (ri_wide < DepthWide) && used_reg[ri_wide[IdxW-1:0]];
            end
            OP_RECORD:
            begin
                found_next   = |match_reg;
                sel_idx_next = found_next ? enc_idx : fill_reg[IdxW-1:0];
            end
            default:
            begin
                sel_idx_next = '0;
                found_next   = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  state_next = q_valid ? ST_MATCH : ST_IDLE;
            ST_MATCH: state_next = ST_ENC;
            ST_ENC:   state_next = ST_UPD;
            ST_UPD:   state_next = slot_free ? ST_IDLE : ST_UPD;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Result and table write values.
    always_comb
    begin
        res       = '0;
        tbl_write = 1'b0;
        key_write = 1'b0;
        wr_idx    = sel_idx_reg;
        any_w     = item_reg.stamp;
        pay_w     = item_reg.has_payload ? item_reg.stamp : pay_rd_reg;
        flag_w    = item_reg.has_payload ? flag_rd_reg : item_reg.stamp;
        idx_wide  = {{IndexOutWidth{1'b0}}, sel_idx_reg};
        unique case (item_reg.op)
            OP_READ:
            begin
                res.entry_index = item_reg.read_index;
                if (found_reg)
                begin
                    res.entry_valid       = 1'b1;
                    res.flow_src_ip       = key_rd_reg[95:64];
                    res.flow_dst_ip       = key_rd_reg[63:32];
                    res.flow_sport        = key_rd_reg[31:16];
                    res.flow_dport        = key_rd_reg[15:0];
                    res.last_any_time     = any_rd_reg;
                    res.last_payload_time = pay_rd_reg;
                    res.last_flag_time    = flag_rd_reg;
                end
            end
            OP_RECORD:
            begin
                if (!found_reg && (fill_reg == DepthFill))
                begin
                    res.table_full = 1'b1;
                end
                else
                begin
                    tbl_write = 1'b1;
                    key_write = !found_reg;
                    if (!found_reg)
                    begin
                        pay_w  = item_reg.has_payload ? item_reg.stamp : 32'd0;
                        flag_w = item_reg.has_payload ? 32'd0 : item_reg.stamp;
                    end
                    res.entry_valid       = 1'b1;
                    res.entry_index       = idx_wide[IndexOutWidth-1:0];
                    res.was_new           = !found_reg;
                    res.flow_src_ip       = item_reg.src_ip;
                    res.flow_sport        = item_reg.sport;
                    res.flow_dst_ip       = item_reg.dst_ip;
                    res.flow_dport        = item_reg.dport;
                    res.last_any_time     = any_w;
                    res.last_payload_time = pay_w;
                    res.last_flag_time    = flag_w;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_upd && key_write)
            begin
                used_reg[wr_idx] <= 1'b1;
                fill_reg         <= fill_reg + FillW'(1);
            end
            if (do_upd)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the key store.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == ST_MATCH)
        begin
            match_reg <= match_vec;
        end
        if (state_reg == ST_ENC)
        begin
            sel_idx_reg <= sel_idx_next;
            found_reg   <= found_next;
            key_rd_reg  <= key_reg[sel_idx_next];
        end
        if (do_upd)
        begin
            out_res_reg <= res;
        end
        if (do_upd && key_write)
        begin
            key_reg[wr_idx] <= {item_reg.src_ip, item_reg.dst_ip,
                                item_reg.sport, item_reg.dport};
        end
    end

    // Time memories: one write port, one registered read port each.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ENC)
        begin
            any_rd_reg  <= any_mem[sel_idx_next];
            pay_rd_reg  <= pay_mem[sel_idx_next];
            flag_rd_reg <= flag_mem[sel_idx_next];
        end
        if (do_upd && tbl_write)
        begin
            any_mem[wr_idx]  <= any_w;
            pay_mem[wr_idx]  <= pay_w;
            flag_mem[wr_idx] <= flag_w;
        end
    end

    // The fill count tracks the used entries exactly.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == int'(fill_reg))
        else $error("fill count disagrees with used entries");

    // Stored keys are unique, so at most one entry matches.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ENC) |-> $onehot0(match_reg))
        else $error("more than one entry matched the key");

    // A new entry is only claimed while room remains.
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_upd && key_write) |-> (fill_reg < DepthFill))
        else $error("entry claimed in a full table");

endmodule
`default_nettype wire

FILE: rtl/tcp_flow_last_seen_table_unit.sv
// Top level of the TCP flow last-seen table with its register port.
//
// Items arrive on the s_axis channel: tuser carries the operation (record or
// read), tdata the flow key, packet time, payload flag and read index. Each item
// gives exactly one result on the m_axis channel, in order.
// A record looks its four-tuple up in the table, claims the next free entry for
// a new flow and stores the offset time as last-seen and as last-payload or
// last-flag-only time, or sets table_full if no entry is free. A read returns
// the entry at read_index. An item passes the queue, then the item, match and
// index/read registers and the result register. The back end takes one item at
// a time: it picks it up, compares all entries, encodes and reads the time
// memories, then updates and loads the result before taking the next item.
// A two-entry queue behind the input lets the input keep taking items while
// the back end works, and a result register holds a finished result while the
// receiver stalls; the back end waits for it to drain.
// Reset empties the table and the queue and sets time_offset to 28800.
// time_offset is written over the APB port at byte address 0.
`default_nettype none
module tcp_flow_last_seen_table_unit
    import ftab_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDefault
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ApbAddrWidth-1:0] paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // src_ip, sport, dst_ip, dport, packet_time, has_payload, read_index
    input  wire logic [135:0]            s_axis_tdata,
    // operation
    input  wire logic                    s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // entry_valid, entry_index, was_new, table_full, flow_src_ip, flow_sport,
    // flow_dst_ip, flow_dport, last_any_time, last_payload_time, last_flag_time
    output logic [207:0]                 m_axis_tdata
);

    logic [OffsetWidth-1:0] time_offset_reg;
    item_t                  in_item;
    item_t                  q_item;
    logic                   q_valid;
    logic                   q_pop;
    result_t                res;

    // Register port.
    assign pready = 1'b1;
    assign prdata = (paddr == AddrTimeOffset) ? {{(32-OffsetWidth){1'b0}}, time_offset_reg}
                                              : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_offset_reg <= OffsetReset;
        end
        else if (psel && penable && pwrite && pready && (paddr == AddrTimeOffset))
        begin
            time_offset_reg <= pwdata[OffsetWidth-1:0];
        end
    end

    // Unpack the input transfer.
    always_comb
    begin
        in_item.op          = op_t'(s_axis_tuser);
        in_item.src_ip      = s_axis_tdata[31:0];
        in_item.sport       = s_axis_tdata[47:32];
        in_item.dst_ip      = s_axis_tdata[79:48];
        in_item.dport       = s_axis_tdata[95:80];
        in_item.stamp       = s_axis_tdata[127:96];
        in_item.has_payload = s_axis_tdata[128];
        in_item.read_index  = s_axis_tdata[134:129];
    end

    ftab_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_item     (in_item),
        .time_offset (time_offset_reg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item)
    );

    ftab_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // Pack the result transfer.
    assign m_axis_tdata = {7'd0,
                           res.last_flag_time,
                           res.last_payload_time,
                           res.last_any_time,
                           res.flow_dport,
                           res.flow_dst_ip,
                           res.flow_sport,
                           res.flow_src_ip,
                           res.table_full,
                           res.was_new,
                           res.entry_index,
                           res.entry_valid};

endmodule
`default_nettype wire

FILE: verif/tcp_flow_last_seen_table_unit_tb.sv
// Self-checking testbench for the TCP flow last-seen table unit.
`timescale 1ns / 1ps
module tcp_flow_last_seen_table_unit_tb;
    import ftab_pkg::*;

    localparam int Depth = 64;
    localparam int StallLimit = 20000;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [ApbAddrWidth-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [207:0] m_axis_tdata;

    tcp_flow_last_seen_table_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    typedef struct {
        op_t         op;
        logic [31:0] src_ip;
        logic [15:0] sport;
        logic [31:0] dst_ip;
        logic [15:0] dport;
        logic [31:0] pkt_time;
        logic        has_payload;
        logic [5:0]  read_index;
    } pkt_t;

    typedef struct {
        logic        entry_valid;
        logic [5:0]  entry_index;
        logic        was_new;
        logic        table_full;
        logic [31:0] flow_src_ip;
        logic [15:0] flow_sport;
        logic [31:0] flow_dst_ip;
        logic [15:0] flow_dport;
        logic [31:0] last_any_time;
        logic [31:0] last_payload_time;
        logic [31:0] last_flag_time;
    } entry_res_t;

    // One stimulus row; a fixed row carries its expected result typed in.
    typedef struct {
        pkt_t p;
        bit   fixed;
        entry_res_t r;
    } row_t;

    // Predictor's copy of the table.
    logic [31:0] tbl_sip [Depth];
    logic [31:0] tbl_dip [Depth];
    logic [15:0] tbl_sport [Depth];
    logic [15:0] tbl_dport [Depth];
    logic        tbl_used [Depth];
    logic [31:0] tbl_any [Depth];
    logic [31:0] tbl_pay [Depth];
    logic [31:0] tbl_flag [Depth];
    int          tbl_fill;
    logic [17:0] cur_offset;

    entry_res_t expected_entries[$];
    row_t       pending_rows[$];
    int         error_count;
    int         idle_cycles;
    int         results_seen;
    int         flows_full_seen;
    bit         sink_hold;
    bit         no_idle;

    // Key pool so that records revisit known flows.
    logic [95:0] key_pool[$];

    function automatic entry_res_t entry_view(int idx);
        entry_res_t r;
        r = '{default: '0};
        r.entry_valid = 1'b1;
        r.entry_index = idx[5:0];
        r.flow_src_ip = tbl_sip[idx];
        r.flow_sport = tbl_sport[idx];
        r.flow_dst_ip = tbl_dip[idx];
        r.flow_dport = tbl_dport[idx];
        r.last_any_time = tbl_any[idx];
        r.last_payload_time = tbl_pay[idx];
        r.last_flag_time = tbl_flag[idx];
        return r;
    endfunction

    // Work out the result of one packet and update the table copy.
    function automatic entry_res_t table_update(pkt_t p);
        entry_res_t r;
        int idx;
        bit found;
        logic [31:0] t;
        r = '{default: '0};
        idx = 0;
        found = 0;
        if (p.op == OP_READ)
        begin
            r.entry_index = p.read_index;
            if (tbl_used[p.read_index])
                r = entry_view(int'(p.read_index));
            return r;
        end
        for (int i = 0; i < Depth; i++)
        begin
            if (!found && tbl_used[i] && tbl_sip[i] == p.src_ip && tbl_dip[i] == p.dst_ip
                && tbl_sport[i] == p.sport && tbl_dport[i] == p.dport)
            begin
                idx = i;
                found = 1;
            end
        end
        if (!found)
        begin
            if (tbl_fill >= Depth)
            begin
                r.table_full = 1'b1;
                return r;
            end
            idx = tbl_fill;
            tbl_fill++;
            tbl_used[idx] = 1'b1;
            tbl_sip[idx] = p.src_ip;
            tbl_dip[idx] = p.dst_ip;
            tbl_sport[idx] = p.sport;
            tbl_dport[idx] = p.dport;
            tbl_any[idx] = '0;
            tbl_pay[idx] = '0;
            tbl_flag[idx] = '0;
        end
        t = p.pkt_time + {{14{cur_offset[17]}}, cur_offset};
        tbl_any[idx] = t;
        if (p.has_payload)
            tbl_pay[idx] = t;
        else
            tbl_flag[idx] = t;
        r = entry_view(idx);
        r.was_new = !found;
        return r;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver side: random stalls, long hold-offs on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (sink_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 31);
    end

    // Result checking against the oldest expectation.
    always @(posedge clk)
    begin
        entry_res_t e;
        result_t a;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            a = {m_axis_tdata[0], m_axis_tdata[6:1], m_axis_tdata[7], m_axis_tdata[8],
                 m_axis_tdata[40:9], m_axis_tdata[56:41], m_axis_tdata[88:57],
                 m_axis_tdata[104:89], m_axis_tdata[136:105], m_axis_tdata[168:137],
                 m_axis_tdata[200:169]};
            results_seen <= results_seen + 1;
            if (expected_entries.size() == 0)
            begin
                $error("result transfer with nothing expected");
                error_count <= error_count + 1;
            end
            else
            begin
                e = expected_entries.pop_front();
                if (a.table_full)
                    flows_full_seen <= flows_full_seen + 1;
                if (a.entry_valid !== e.entry_valid ||
                    a.entry_index !== e.entry_index || a.was_new !== e.was_new ||
                    a.table_full !== e.table_full || a.flow_src_ip !== e.flow_src_ip ||
                    a.flow_sport !== e.flow_sport ||
                    a.flow_dst_ip !== e.flow_dst_ip ||
                    a.flow_dport !== e.flow_dport ||
                    a.last_any_time !== e.last_any_time ||
                    a.last_payload_time !== e.last_payload_time ||
                    a.last_flag_time !== e.last_flag_time)
                begin
                    error_count <= error_count + 1;
                    if (a.entry_valid !== e.entry_valid)
                        $error("entry_valid exp %0h got %0h", e.entry_valid, a.entry_valid);
                    if (a.entry_index !== e.entry_index)
                        $error("entry_index exp %0h got %0h", e.entry_index, a.entry_index);
                    if (a.was_new !== e.was_new)
                        $error("was_new exp %0h got %0h", e.was_new, a.was_new);
                    if (a.table_full !== e.table_full)
                        $error("table_full exp %0h got %0h", e.table_full, a.table_full);
                    if (a.flow_src_ip !== e.flow_src_ip)
                        $error("flow_src_ip exp %0h got %0h", e.flow_src_ip, a.flow_src_ip);
                    if (a.flow_sport !== e.flow_sport)
                        $error("flow_sport exp %0h got %0h", e.flow_sport, a.flow_sport);
                    if (a.flow_dst_ip !== e.flow_dst_ip)
                        $error("flow_dst_ip exp %0h got %0h", e.flow_dst_ip, a.flow_dst_ip);
                    if (a.flow_dport !== e.flow_dport)
                        $error("flow_dport exp %0h got %0h", e.flow_dport, a.flow_dport);
                    if (a.last_any_time !== e.last_any_time)
                        $error("last_any_time exp %0h got %0h", e.last_any_time,
                               a.last_any_time);
                    if (a.last_payload_time !== e.last_payload_time)
                        $error("last_payload_time exp %0h got %0h", e.last_payload_time,
                               a.last_payload_time);
                    if (a.last_flag_time !== e.last_flag_time)
                        $error("last_flag_time exp %0h got %0h", e.last_flag_time,
                               a.last_flag_time);
                end
            end
        end
    end

    // Expectation is formed when an input transfer is accepted; fixed rows keep
    // their typed-in result while the predictor still tracks the table.
    always @(posedge clk)
    begin
        row_t w;
        entry_res_t e;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            w = pending_rows.pop_front();
            e = table_update(w.p);
            if (w.fixed)
                e = w.r;
            expected_entries.push_back(e);
        end
    end

    // Register write, setup then access cycle.
    task automatic write_offset(logic [17:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AddrTimeOffset;
        pwdata <= {{14{value[17]}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        cur_offset = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one row and hold it until transferred; valid stays up until the
    // next idle cycle, row or drain lowers it.
    task automatic send_row(row_t w, bit gaps);
        while (gaps && !no_idle && $urandom_range(99) < 31)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        pending_rows.push_back(w);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= w.p.op;
        s_axis_tdata <= {1'b0, w.p.read_index, w.p.has_payload, w.p.pkt_time, w.p.dport,
                         w.p.dst_ip, w.p.sport, w.p.src_ip};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic send_pkt(pkt_t p, bit gaps);
        row_t w;
        w.p = p;
        w.fixed = 0;
        w.r = '{default: '0};
        send_row(w, gaps);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_entries.size() != 0 || pending_rows.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic pkt_t random_pkt(bit mostly_known);
        pkt_t p;
        logic [95:0] k;
        p.op = ($urandom_range(99) < 20) ? OP_READ : OP_RECORD;
        if (mostly_known && key_pool.size() > 0 && $urandom_range(99) < 70)
        begin
            k = key_pool[$urandom_range(key_pool.size() - 1)];
        end
        else
        begin
            k = {$urandom(), $urandom(), $urandom()};
            if (p.op == OP_RECORD)
                key_pool.push_back(k);
        end
        {p.src_ip, p.dst_ip, p.sport, p.dport} = k;
        p.pkt_time = $urandom();
        p.has_payload = 1'($urandom_range(1));
        p.read_index = 6'($urandom_range(63));
        return p;
    endfunction

    // Directed rows, checked against fixed values where obvious.
    initial
    begin
        row_t rows[$];
        row_t w;
        entry_res_t z;
        pkt_t p;
        int n_items;
        error_count = 0;
        idle_cycles = 0;
        results_seen = 0;
        flows_full_seen = 0;
        sink_hold = 0;
        no_idle = 0;
        tbl_fill = 0;
        cur_offset = OffsetReset;
        for (int i = 0; i < Depth; i++)
        begin
            tbl_used[i] = 0;
            tbl_sip[i] = '0; tbl_dip[i] = '0; tbl_sport[i] = '0; tbl_dport[i] = '0;
            tbl_any[i] = '0; tbl_pay[i] = '0; tbl_flag[i] = '0;
        end
        rst_n <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        s_axis_tvalid <= 1'b0; s_axis_tdata <= '0; s_axis_tuser <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty reads, extreme keys, offset wrap to zero.
        z = '{default: '0};
        w.p = '{OP_READ, 32'h0, 16'h0, 32'h0, 16'h0, 32'h0, 1'b0, 6'd0};
        w.fixed = 1; w.r = z; rows.push_back(w);
        w.p.read_index = 6'd63; w.r.entry_index = 6'd63; rows.push_back(w);
        w.fixed = 0;
        w.p = '{OP_RECORD, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF,
                1'b1, 6'd63};
        rows.push_back(w);
        w.p.has_payload = 0; w.p.pkt_time = -32'sd28800; rows.push_back(w);
        w.p = '{OP_RECORD, 32'h0, 16'h0, 32'h0, 16'h0, 32'h0, 1'b0, 6'd0};
        rows.push_back(w);
        w.p.has_payload = 1; rows.push_back(w);
        w.p = '{OP_READ, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF,
                1'b1, 6'd0};
        rows.push_back(w);
        w.p.read_index = 6'd1; rows.push_back(w);
        w.p.read_index = 6'd2; w.fixed = 1; w.r = z; w.r.entry_index = 6'd2;
        rows.push_back(w);
        foreach (rows[i])
        begin
            send_row(rows[i], 1);
            if (rows[i].fixed)
            begin
                wait_drain();
            end
        end
        wait_drain();

        // Offset extremes, including values outside the nominal range.
        write_offset(18'h20000);
        p = '{OP_RECORD, 32'h1, 16'h1, 32'h2, 16'h2, 32'h0, 1'b1, 6'd0};
        send_pkt(p, 1);
        wait_drain();
        write_offset(18'h1FFFF);
        p.pkt_time = 32'hFFFFFFFF; p.has_payload = 0;
        send_pkt(p, 1);
        wait_drain();
        write_offset(-18'sd86400);
        send_pkt(p, 1);
        wait_drain();
        write_offset(18'd86400);

        // Random part: mostly known flows; fill the table to force drops.
        n_items = 0;
        while (n_items < 750)
        begin
            if (n_items == 150) no_idle = 1;
            if (n_items == 250) no_idle = 0;
            if (n_items == 300)
            begin
                fork
                    begin
                        sink_hold = 1;
                        repeat (200) @(posedge clk);
                        sink_hold = 0;
                    end
                join_none
            end
            if (n_items == 400 || n_items == 600)
            begin
                wait_drain();
                write_offset(18'($urandom()));
            end
            send_pkt(random_pkt(n_items < 400 || tbl_fill >= Depth), 1);
            n_items++;
        end
        wait_drain();
        repeat (20) @(posedge clk);

        $display("Ran %0d results, %0d flows in table, %0d dropped on a full table.",
                 results_seen, tbl_fill, flows_full_seen);
        if (error_count == 0 && expected_entries.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: sim.f
rtl/ftab_pkg.sv
rtl/ftab_front.sv
rtl/ftab_back.sv
rtl/tcp_flow_last_seen_table_unit.sv
verif/tcp_flow_last_seen_table_unit_tb.sv
